### hw/rtl/dmc_pkg.sv
// Shared types and constants for the direct-mapped cache miss counter.
package dmc_pkg;

    localparam int ADDR_W    = 32;  // byte address and block number width
    localparam int DIVISOR_W = 17;  // widest divisor: block size or line count
    localparam int BBYTES_W  = 17;
    localparam int LCOUNT_W  = 11;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 1;

    localparam int ADDR_BITS       = 32;
    localparam int DEF_MAX_LINES   = 1024;

    localparam logic [BBYTES_W-1:0] BLOCK_BYTES_RST = 17'd64;
    localparam logic [LCOUNT_W-1:0] LINE_COUNT_RST  = 11'd1024;

    localparam logic [ADDR_W-1:0] ADDR_MASK =
        (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT  = 1'b1;

    typedef struct packed {
        logic [BBYTES_W-1:0] block_bytes;
        logic [LCOUNT_W-1:0] line_count;
    } t_cfg;

    // one classified access handed from front to back
    typedef struct packed {
        logic                 rd;
        logic [ADDR_W-1:0]    blk;
        logic [DIVISOR_W-1:0] line;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

### hw/rtl/dmc_div.sv
// Iterative unsigned divider, two quotient bits per cycle.
module dmc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dmc_pkg::ADDR_W-1:0]    i_dividend,
    input  logic [dmc_pkg::DIVISOR_W-1:0] i_divisor,
    output logic                          o_done,
    output logic [dmc_pkg::ADDR_W-1:0]    o_quotient,
    output logic [dmc_pkg::DIVISOR_W-1:0] o_remainder
);
    import dmc_pkg::*;

    localparam int STEPS = ADDR_W / 2;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                 r_run;
    logic                 r_done;
    logic [STEP_W-1:0]    r_cnt;
    logic [ADDR_W-1:0]    r_q;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_div;

    logic [DIVISOR_W:0]   t1, t2, sub1, sub2, dv;
    logic                 ge1, ge2;
    logic [DIVISOR_W-1:0] rem1, rem2;

    // two restoring steps
    always_comb begin
        dv   = {1'b0, r_div};
        t1   = {r_rem, r_q[ADDR_W-1]};
        ge1  = (t1 >= dv);
        sub1 = t1 - dv;
        rem1 = ge1 ? sub1[DIVISOR_W-1:0] : t1[DIVISOR_W-1:0];
        t2   = {rem1, r_q[ADDR_W-2]};
        ge2  = (t2 >= dv);
        sub2 = t2 - dv;
        rem2 = ge2 ? sub2[DIVISOR_W-1:0] : t2[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= STEP_W'(STEPS - 1);
                r_q   <= i_dividend;
                r_rem <= '0;
                r_div <= i_divisor;
            end else if (r_run) begin
                r_q   <= {r_q[ADDR_W-3:0], ge1, ge2};
                r_rem <= rem2;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

### hw/rtl/dmc_front.sv
// Front end: takes accesses, splits reads into block number and line index.
module dmc_front #(
    parameter int MAX_LINES = dmc_pkg::DEF_MAX_LINES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dmc_pkg::t_cfg              i_cfg,
    input  logic                       i_accept,
    input  logic                       i_op,
    input  logic [dmc_pkg::ADDR_W-1:0] i_byte_address,
    output logic                       o_idle,
    output logic                       o_push,
    output dmc_pkg::t_job              o_job
);
    import dmc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_BLK,
        ST_DIV_LINE
    } t_state;

    t_state r_state;
    logic [ADDR_W-1:0] r_blk;

    logic [DIVISOR_W-1:0] eff_div, eff_lines, lc_ext, div_sor;
    logic [ADDR_W-1:0]    div_end, quot;
    logic [DIVISOR_W-1:0] rem;
    logic                 div_start, div_done;

    always_comb begin
        eff_div = (i_cfg.block_bytes == '0) ? DIVISOR_W'(1) : DIVISOR_W'(i_cfg.block_bytes);
        lc_ext  = DIVISOR_W'(i_cfg.line_count);
        if (lc_ext == '0) begin
            eff_lines = DIVISOR_W'(1);
        end else if (lc_ext > DIVISOR_W'(MAX_LINES)) begin
            eff_lines = DIVISOR_W'(MAX_LINES);
        end else begin
            eff_lines = lc_ext;
        end
    end

    always_comb begin
        div_start = 1'b0;
        div_end   = i_byte_address & ADDR_MASK;
        div_sor   = eff_div;
        o_push    = 1'b0;
        o_job     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    div_start = i_op;
                    o_push    = !i_op;  // non-reads pass straight through
                end
            end
            ST_DIV_BLK: begin
                div_start = div_done;
                div_end   = quot;
                div_sor   = eff_lines;
            end
            ST_DIV_LINE: begin
                o_push    = div_done;
                o_job.rd   = 1'b1;
                o_job.blk  = r_blk;
                o_job.line = rem;
            end
            default: ;
        endcase
    end

    dmc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_end),
        .i_divisor   (div_sor),
        .o_done      (div_done),
        .o_quotient  (quot),
        .o_remainder (rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_accept && i_op) r_state <= ST_DIV_BLK;
                end
                ST_DIV_BLK: begin
                    if (div_done) begin
                        r_blk   <= quot;
                        r_state <= ST_DIV_LINE;
                    end
                end
                ST_DIV_LINE: begin
                    if (div_done) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_idle = (r_state == ST_IDLE);

endmodule

### hw/rtl/dmc_queue.sv
// Two-entry job queue between front and back.
module dmc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dmc_pkg::t_job   i_job,
    input  logic            i_pop,
    output dmc_pkg::t_job   o_head,
    output dmc_pkg::t_qstat o_stat
);
    import dmc_pkg::*;

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule

### hw/rtl/dmc_back.sv
// Back end: line lookup, replacement check, counter and result register.
module dmc_back #(
    parameter int MAX_LINES = dmc_pkg::DEF_MAX_LINES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dmc_pkg::t_qstat           i_qstat,
    input  dmc_pkg::t_job             i_head,
    output logic                      o_pop,
    output logic                      o_ready,
    output logic                      o_strobe,
    output logic                      o_replaced,
    output logic                      o_counted,
    output logic [dmc_pkg::CNT_W-1:0] o_total
);
    import dmc_pkg::*;

    localparam int LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } t_state;

    t_state r_state;
    logic [LINE_W-1:0] r_clr;
    t_job              r_cur;
    logic [CNT_W-1:0]  r_count;
    logic              r_strobe, r_replaced, r_counted;
    logic [CNT_W-1:0]  r_total;

    logic              r_valid_mem [MAX_LINES];
    logic [ADDR_W-1:0] r_blk_mem   [MAX_LINES];
    logic              r_vld_rd;
    logic [ADDR_W-1:0] r_blk_rd;

    logic [LINE_W-1:0] rd_addr, wr_addr;
    logic              v_we, v_wd, b_we, repl;
    logic [CNT_W-1:0]  n_count;

    assign rd_addr = i_head.line[LINE_W-1:0];
    assign o_pop   = (r_state == ST_IDLE) && !i_qstat.empty;
    assign o_ready = (r_state != ST_CLEAR);

    always_comb begin
        wr_addr = (r_state == ST_CLEAR) ? r_clr : r_cur.line[LINE_W-1:0];
        v_we    = (r_state == ST_CLEAR) || (r_state == ST_LOOK);
        v_wd    = (r_state == ST_LOOK);
        b_we    = (r_state == ST_LOOK);
        repl    = r_vld_rd && (r_blk_rd != r_cur.blk);
        n_count = (repl && (r_count != CNT_MAX)) ? r_count + 1'b1 : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (v_we) r_valid_mem[wr_addr] <= v_wd;
        if (b_we) r_blk_mem[wr_addr]   <= r_cur.blk;
        r_vld_rd <= r_valid_mem[rd_addr];
        r_blk_rd <= r_blk_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LINE_W'(MAX_LINES - 1)) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_cur <= i_head;
                        if (i_head.rd) begin
                            r_state <= ST_LOOK;
                        end else begin
                            r_strobe   <= 1'b1;
                            r_replaced <= 1'b0;
                            r_counted  <= 1'b0;
                            r_total    <= r_count;
                        end
                    end
                end
                ST_LOOK: begin
                    r_strobe   <= 1'b1;
                    r_replaced <= repl;
                    r_counted  <= 1'b1;
                    r_total    <= n_count;
                    r_count    <= n_count;
                    r_state    <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_strobe   = r_strobe;
    assign o_replaced = r_replaced;
    assign o_counted  = r_counted;
    assign o_total    = r_total;

endmodule

### hw/rtl/direct_mapped_cache_miss_counter.sv
// Top level of the direct-mapped cache replacement counter.
//
//  channel   | direction | handshake                       | beat
//  ----------+-----------+---------------------------------+-------------------------------
//  access    | in        | start high, busy low            | i_op, i_byte_address
//  result    | out       | o_strobe, one cycle, no stall   | o_replaced, o_counted,
//            |           |                                 | o_replacement_total
//  config    | in        | i_cfg_valid and o_cfg_ready     | i_cfg_index, i_cfg_data
//
// A read occupies the front for two passes of the shared 2-bit-per-cycle divider
// (block number, then line index) before its job is pushed to the queue; a
// non-read bypasses the divider and is pushed on its accept. The back end reads
// the line store (registered read) and writes it back in the next cycle, so it
// takes no new job while a read is being written back. After reset the line
// valid store is cleared one entry a cycle, and busy stays high until every
// entry is clear. Config writes are always taken.
// The result side cannot stall; the two-entry queue lets the front start the
// next access while the back end finishes the previous one.
module direct_mapped_cache_miss_counter #(
    parameter int MAX_LINES = dmc_pkg::DEF_MAX_LINES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [dmc_pkg::ADDR_W-1:0]    i_byte_address,
    output logic                          o_strobe,
    output logic                          o_replaced,
    output logic                          o_counted,
    output logic [dmc_pkg::CNT_W-1:0]     o_replacement_total,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dmc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dmc_pkg::BBYTES_W-1:0]  i_cfg_data
);
    import dmc_pkg::*;

    t_cfg   r_cfg;
    t_job   push_job, head;
    t_qstat qstat;
    logic   accept, front_idle, push, pop, back_ready;

    // config registers; the user must write them only while the block is idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_bytes <= BLOCK_BYTES_RST;
            r_cfg.line_count  <= LINE_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BLOCK_BYTES: r_cfg.block_bytes <= i_cfg_data;
                CFG_LINE_COUNT:  r_cfg.line_count  <= i_cfg_data[LCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // front must be free and the queue must have room; no work during clear
    assign busy   = !back_ready || !front_idle || qstat.full;
    assign accept = start && !busy;

    dmc_front #(.MAX_LINES(MAX_LINES)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_accept       (accept),
        .i_op           (i_op),
        .i_byte_address (i_byte_address),
        .o_idle         (front_idle),
        .o_push         (push),
        .o_job          (push_job)
    );

    dmc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    dmc_back #(.MAX_LINES(MAX_LINES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qstat    (qstat),
        .i_head     (head),
        .o_pop      (pop),
        .o_ready    (back_ready),
        .o_strobe   (o_strobe),
        .o_replaced (o_replaced),
        .o_counted  (o_counted),
        .o_total    (o_replacement_total)
    );

endmodule

### hw/rtl/dmc_checker.sv
// Port-level checks for the cache replacement counter, bound to the top level.
module dmc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_strobe,
    input logic                          o_replaced,
    input logic                          o_counted,
    input logic [dmc_pkg::CNT_W-1:0]     o_replacement_total
);
    import dmc_pkg::*;

    logic [CNT_W-1:0] r_last;
    logic [3:0]       r_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= '0;
            r_pending <= '0;
        end else begin
            if (o_strobe) r_last <= o_replacement_total;
            unique case ({start && !busy, o_strobe})
                2'b10:   r_pending <= r_pending + 1'b1;
                2'b01:   r_pending <= r_pending - 1'b1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    a_quiet_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

    a_repl_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_replaced |-> o_counted)
        else $error("replacement reported on an access that was not looked up");

    a_total_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_replaced |-> o_replacement_total == r_last)
        else $error("total moved without a replacement");

    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_replaced |->
            (o_replacement_total == r_last + 1'b1) ||
            (r_last == CNT_MAX && o_replacement_total == CNT_MAX))
        else $error("total did not advance by one on a replacement");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> r_pending != '0)
        else $error("result with no access outstanding");

endmodule

bind direct_mapped_cache_miss_counter dmc_checker u_dmc_checker (.*);
